FILE: rtl/brwt_pkg.sv
// Shared types and constants for the band release weight tracker.
`default_nettype none
package brwt_pkg;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;  // 10*log10(2) in Q16

  localparam logic [2:0] REG_RISE_COEF = 3'd0;
  localparam logic [2:0] REG_FALL_COEF = 3'd1;
  localparam logic [2:0] REG_GAP_ONSET = 3'd2;
  localparam logic [2:0] REG_INV_RANGE = 3'd3;
  localparam logic [2:0] REG_ENERGY_FLOOR = 3'd4;

  typedef struct packed {
    logic [15:0]        rise_coef;
    logic [15:0]        fall_coef;
    logic signed [15:0] gap_onset_db;
    logic [15:0]        inv_gap_range;
    logic [15:0]        energy_floor;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  band;
    logic [31:0] sum;
    logic        seeded;
    logic        last;
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/brwt_if.sv
// Request channel interfaces for bins in and weights out.
`default_nettype none
interface brwt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] magnitude;
  logic [4:0]  band_number;
  logic        in_band;
  logic        band_end;
  logic        frame_end;
  modport source (output valid, mode, magnitude, band_number, in_band, band_end, frame_end,
                  input ready);
  modport sink (input valid, mode, magnitude, band_number, in_band, band_end, frame_end,
                output ready);
endinterface

interface brwt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  result_band;
  logic [16:0] weight;
  logic        last_band;
  modport source (output valid, result_band, weight, last_band, input ready);
  modport sink (input valid, result_band, weight, last_band, output ready);
endinterface
`default_nettype wire

FILE: rtl/brwt_front.sv
// Front end: accepts bins, keeps the band sum and seeding flag, emits band jobs.
`default_nettype none
module brwt_front #(
  parameter int unsigned BANDS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  brwt_in_if.sink            in_ch,
  input  wire logic          q_full,
  output brwt_pkg::job_t     push_job,
  output logic               push
);
  import brwt_pkg::*;

  logic [31:0] sum_r, sum_nxt;
  logic        seeded_r, seeded_nxt;
  logic        acc;
  logic        band_ok;
  logic [32:0] add;
  logic [31:0] sat;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign band_ok = in_ch.in_band && ({27'd0, in_ch.band_number} < 32'(BANDS));
  assign add = {1'b0, sum_r} + {9'd0, in_ch.magnitude};
  assign sat = add[32] ? 32'hFFFF_FFFF : add[31:0];

  always_comb begin
    sum_nxt = sum_r;
    seeded_nxt = seeded_r;
    push = 1'b0;
    push_job.band = in_ch.band_number;
    push_job.sum = sat;
    push_job.seeded = seeded_r;
    push_job.last = in_ch.frame_end;
    if (acc) begin
      if (in_ch.mode) begin
        sum_nxt = '0;
        seeded_nxt = 1'b0;
      end else begin
        if (band_ok) begin
          sum_nxt = sat;
          if (in_ch.band_end) begin
            push = 1'b1;
            sum_nxt = '0;
          end
        end
        if (in_ch.frame_end) begin
          seeded_nxt = 1'b1;
          sum_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      seeded_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      seeded_r <= seeded_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/brwt_queue.sv
// Short job queue between the front end and the weight engine.
`default_nettype none
module brwt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire brwt_pkg::job_t push_job,
  input  wire logic           pop,
  output brwt_pkg::job_t      head,
  output logic                empty,
  output logic                full
);
  import brwt_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (QAW+1)'(QDEPTH));
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/brwt_log2.sv
// Iterative log2 in Q5.16: normalize, then one squaring per cycle.
`default_nettype none
module brwt_log2 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output logic             done,
  output logic [20:0]      result
);
  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

  lstate_t     st_r;
  logic [31:0] m_r;
  logic [4:0]  sh_r;
  logic [3:0]  it_r;
  logic [15:0] frac_r;
  logic        done_r;
  logic [63:0] sq;
  logic [32:0] t;

  assign sq = 64'(m_r) * 64'(m_r);
  assign t = sq[63:31];
  assign done = done_r;
  assign result = {5'd31 - sh_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) begin
            m_r <= (x == '0) ? 32'd1 : x;
            sh_r <= '0;
            st_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (m_r[31]) begin
            it_r <= '0;
            frac_r <= '0;
            st_r <= L_SQ;
          end else if (m_r[31:24] == '0) begin
            m_r <= {m_r[23:0], 8'd0};
            sh_r <= sh_r + 5'd8;
          end else begin
            m_r <= {m_r[30:0], 1'b0};
            sh_r <= sh_r + 5'd1;
          end
        end
        L_SQ: begin
          frac_r <= {frac_r[14:0], t[32]};
          m_r <= t[32] ? t[32:1] : t[31:0];
          it_r <= it_r + 4'd1;
          if (it_r == 4'd15) begin
            done_r <= 1'b1;
            st_r <= L_IDLE;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/brwt_back.sv
// Weight engine: envelope store, log gap, weight and envelope smoothing.
`default_nettype none
module brwt_back #(
  parameter int unsigned BANDS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire brwt_pkg::cfg_t  cfg,
  input  wire brwt_pkg::job_t  head,
  input  wire logic            q_empty,
  output logic                 pop,
  brwt_out_if.source           out_ch
);
  import brwt_pkg::*;

  localparam int unsigned AW = (BANDS > 1) ? $clog2(BANDS) : 1;

  typedef enum logic [3:0] {
    B_IDLE, B_PREP, B_LOGE, B_LOGC, B_GAP, B_WGT, B_UPD1, B_UPD2, B_FIN
  } bstate_t;

  bstate_t      st_r;
  job_t         job_r;
  logic [31:0]  env_mem [BANDS];
  logic [31:0]  env_r;
  logic [20:0]  loge_r;
  logic [40:0]  prod_r;
  logic [16:0]  weight_r;
  logic [48:0]  acc_r;
  logic [31:0]  newenv_r;
  logic         out_valid_r;
  logic [4:0]   out_band_r;
  logic [16:0]  out_weight_r;
  logic         out_last_r;

  logic         log_start, log_done;
  logic [31:0]  log_x;
  logic [20:0]  log_res;
  logic [31:0]  cur;
  logic         trivial;
  logic [15:0]  alpha;
  logic [16:0]  beta;
  logic signed [21:0] dlog;
  logic signed [16:0] gap;
  logic signed [17:0] d;
  logic [32:0]  dprod;
  logic [24:0]  drop;
  logic [48:0]  acc_sum;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [6:0]   head_band_x, job_band_x;

  brwt_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .start(log_start), .x(log_x),
    .done(log_done), .result(log_res)
  );

  assign head_band_x = {2'b00, head.band};
  assign job_band_x = {2'b00, job_r.band};
  assign rd_addr = head_band_x[AW-1:0];
  assign wr_addr = job_band_x[AW-1:0];

  assign pop = (st_r == B_IDLE) && !q_empty;
  assign cur = (job_r.sum < {16'd0, cfg.energy_floor}) ? {16'd0, cfg.energy_floor} : job_r.sum;
  assign trivial = env_r <= {16'd0, cfg.energy_floor};
  assign alpha = (job_r.sum >= env_r) ? cfg.rise_coef : cfg.fall_coef;
  assign beta = 17'd65536 - {1'b0, alpha};

  assign log_start = ((st_r == B_PREP) && job_r.seeded && !trivial) ||
                     ((st_r == B_LOGE) && log_done);
  assign log_x = (st_r == B_PREP) ? env_r : cur;

  assign dlog = $signed({1'b0, loge_r}) - $signed({1'b0, log_res});
  assign gap = prod_r[40:24];  // floor shift
  assign d = 18'(gap) - 18'(cfg.gap_onset_db);
  assign dprod = 33'(d[16:0]) * 33'(cfg.inv_gap_range);
  assign drop = dprod[32:8];
  assign acc_sum = acc_r + 49'(beta) * 49'(job_r.sum) + 49'd32768;

  assign out_ch.valid = out_valid_r;
  assign out_ch.result_band = out_band_r;
  assign out_ch.weight = out_weight_r;
  assign out_ch.last_band = out_last_r;

  always_ff @(posedge clk) begin
    if (pop) env_r <= env_mem[rd_addr];
    if ((st_r == B_FIN) && (!out_valid_r || out_ch.ready)) env_mem[wr_addr] <= newenv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        B_IDLE: begin
          if (pop) begin
            job_r <= head;
            st_r <= B_PREP;
          end
        end
        B_PREP: begin
          if (!job_r.seeded) begin
            weight_r <= WEIGHT_ONE;
            newenv_r <= job_r.sum;
            st_r <= B_FIN;
          end else if (trivial) begin
            weight_r <= WEIGHT_ONE;
            st_r <= B_UPD1;
          end else begin
            st_r <= B_LOGE;
          end
        end
        B_LOGE: begin
          if (log_done) begin
            loge_r <= log_res;
            st_r <= B_LOGC;
          end
        end
        B_LOGC: begin
          if (log_done) begin
            prod_r <= 41'(dlog * DB_PER_LOG2);
            st_r <= B_GAP;
          end
        end
        B_GAP: st_r <= B_WGT;
        B_WGT: begin
          if (d <= 18'sd0) weight_r <= WEIGHT_ONE;
          else if (drop > 25'd65536) weight_r <= '0;
          else weight_r <= WEIGHT_ONE - drop[16:0];
          st_r <= B_UPD1;
        end
        B_UPD1: begin
          acc_r <= 49'(alpha) * 49'(env_r);
          st_r <= B_UPD2;
        end
        B_UPD2: begin
          newenv_r <= acc_sum[47:16];
          st_r <= B_FIN;
        end
        B_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_band_r <= job_r.band;
            out_weight_r <= weight_r;
            out_last_r <= job_r.last;
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/band_release_weight_tracker.sv
// Bins in one per cycle while the 4-entry job queue has room; the engine takes one band
// job at a time: a seeding job goes straight to the output, a trivial envelope skips the
// log gap, else two log2 passes (normalize, then 16 squarings) give the gap and weight.
// The weight is registered at the output; bins stream at one per cycle as long as the
// engine keeps pace with the bands and the output is taken, so the queue does not fill.
// Synchronous active-low reset clears sum, seeding flag, queue and engine state;
// the envelope store is not cleared and is seeded by the first frame.
`default_nettype none
module band_release_weight_tracker #(
  parameter int unsigned BANDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  brwt_in_if.sink          in_ch,
  brwt_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import brwt_pkg::*;

  cfg_t        cfg_r;
  job_t        push_job, head;
  logic        push, pop, q_empty, q_full;
  logic        wr;
  logic [2:0]  idx;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[4:2];

  always_comb begin
    case (idx)
      REG_RISE_COEF:     cfg_prdata = {16'd0, cfg_r.rise_coef};
      REG_FALL_COEF:     cfg_prdata = {16'd0, cfg_r.fall_coef};
      REG_GAP_ONSET:     cfg_prdata = {16'd0, cfg_r.gap_onset_db};
      REG_INV_RANGE:     cfg_prdata = {16'd0, cfg_r.inv_gap_range};
      REG_ENERGY_FLOOR:  cfg_prdata = {16'd0, cfg_r.energy_floor};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_coef <= 16'd24109;
      cfg_r.fall_coef <= 16'd60000;
      cfg_r.gap_onset_db <= 16'sd1536;
      cfg_r.inv_gap_range <= 16'd5461;
      cfg_r.energy_floor <= 16'd1;
    end else if (wr) begin
      case (idx)
        REG_RISE_COEF:     cfg_r.rise_coef <= cfg_pwdata[15:0];
        REG_FALL_COEF:     cfg_r.fall_coef <= cfg_pwdata[15:0];
        REG_GAP_ONSET:     cfg_r.gap_onset_db <= cfg_pwdata[15:0];
        REG_INV_RANGE:     cfg_r.inv_gap_range <= cfg_pwdata[15:0];
        REG_ENERGY_FLOOR:  cfg_r.energy_floor <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  brwt_front #(.BANDS(BANDS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_full(q_full),
    .push_job(push_job), .push(push)
  );

  brwt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head(head), .empty(q_empty), .full(q_full)
  );

  brwt_back #(.BANDS(BANDS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .q_empty(q_empty),
    .pop(pop), .out_ch(out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("job pushed into full queue");
  a_restart_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode) |-> !push)
    else $error("restart request produced a job");
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.weight <= WEIGHT_ONE)) else $error("weight above one");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty) else $error("pop from empty queue");
endmodule
`default_nettype wire
